// ===== rtl/sirc_pkg.sv =====
// Shared types and constants for the pulse-width IR frame encoder.
`default_nettype none

package sirc_pkg;

  localparam int CMD_W      = 7;
  localparam int ADDR_W     = 13;
  localparam int NBITS_W    = 5;
  localparam int FRAME_W    = CMD_W + ADDR_W;
  localparam int RATE_W     = 24;
  localparam int TICK_W     = 15;
  // 3 * rate fits in 26 bits; ticks(us) = us/200 * rate / 5000
  localparam int DIVIDEND_W = RATE_W + 2;
  localparam int QUO_W      = 14;
  localparam int REM_W      = 13;
  // floor(d / 5000) = (d * ceil(2^39 / 5000)) >> 39, exact for d < 2^26
  localparam int RECIP_W     = 27;
  localparam int RECIP_SHIFT = 39;
  localparam int PROD_W      = DIVIDEND_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_5000 = 27'd109951163;

  localparam logic [REM_W-1:0]  DIVISOR     = 13'd5000;
  localparam logic [REM_W-1:0]  REM_QUARTER = 13'd1250;
  localparam logic [REM_W-1:0]  REM_HALF    = 13'd2500;
  localparam logic [REM_W-1:0]  REM_3QUART  = 13'd3750;
  localparam logic [TICK_W-1:0] TICK_MAX    = 15'h7FFF;

  // durations at the reset tick rate of 1 MHz
  localparam logic [TICK_W-1:0] RST_GAP_TICKS = 15'd600;
  localparam logic [TICK_W-1:0] RST_ONE_TICKS = 15'd1200;
  localparam logic [TICK_W-1:0] RST_HDR_TICKS = 15'd2400;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_HDR,
    ST_BITS,
    ST_CLOSE
  } sirc_state_t;

  typedef enum logic [1:0] {
    SYM_NONE,
    SYM_HDR,
    SYM_BIT,
    SYM_CLOSE
  } sym_kind_t;

  typedef struct packed {
    logic      load_frame;
    logic      calc_start;
    sym_kind_t emit;
  } sirc_cmd_t;

  typedef struct packed {
    logic calc_done;
    logic no_bits;
    logic last_bit;
  } sirc_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sirc_div.sv =====
// Pipelined divider by the fixed constant 5000 using a reciprocal multiply.
`default_nettype none

module sirc_div
  import sirc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  output logic                       running,
  output logic                       done,
  output logic [QUO_W-1:0]           quo,
  output logic [REM_W-1:0]           rem
);

  logic                  mul_pend;
  logic                  quo_pend;
  logic                  rem_pend;
  logic [DIVIDEND_W-1:0] dvd;
  logic [PROD_W-1:0]     prod;
  logic [DIVIDEND_W-1:0] quo_scaled;
  logic [DIVIDEND_W-1:0] rem_full;

  assign quo_scaled = DIVIDEND_W'(quo) * DIVIDEND_W'(DIVISOR);
  assign rem_full   = dvd - quo_scaled;
  assign running    = mul_pend | quo_pend | rem_pend;

  // a new start drops any calculation still in the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_pend <= 1'b0;
      quo_pend <= 1'b0;
      rem_pend <= 1'b0;
      done     <= 1'b0;
    end else begin
      mul_pend <= start;
      quo_pend <= mul_pend && !start;
      rem_pend <= quo_pend && !start;
      done     <= rem_pend && !start;
    end
  end

  always_ff @(posedge clk) begin
    if (start)    dvd  <= dividend;
    if (mul_pend) prod <= PROD_W'(dvd) * PROD_W'(RECIP_5000);
    if (quo_pend) quo  <= prod[PROD_W-1:RECIP_SHIFT];
    if (rem_pend) rem  <= rem_full[REM_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/sirc_dp.sv =====
// Datapath: tick table, frame shifter, bit counter and result registers.
`default_nettype none

module sirc_dp
  import sirc_pkg::*;
#(
  parameter int MAX_FRAME_BITS = 20
)
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sirc_cmd_t          cmd,
  output sirc_stat_t              stat,
  input  wire logic [RATE_W-1:0]  cfg_data,
  input  wire logic [CMD_W-1:0]   command_code,
  input  wire logic [ADDR_W-1:0]  device_address,
  input  wire logic [NBITS_W-1:0] frame_bits,
  output logic                    strobe,
  output logic                    first_level,
  output logic [TICK_W-1:0]       first_ticks,
  output logic                    second_level,
  output logic [TICK_W-1:0]       second_ticks,
  output logic                    last_symbol
);

  logic [DIVIDEND_W-1:0] dividend;
  logic                  div_running;
  logic                  div_done;
  logic [QUO_W-1:0]      quo;
  logic [REM_W-1:0]      rem;

  logic [TICK_W-1:0]     gap_ticks;
  logic [TICK_W-1:0]     one_ticks;
  logic [TICK_W-1:0]     hdr_ticks;
  logic [TICK_W-1:0]     one_ticks_next;
  logic [TICK_W-1:0]     hdr_ticks_next;
  logic [1:0]            hdr_frac;
  logic [TICK_W:0]       hdr_sum;

  logic [FRAME_W-1:0]    frame;
  logic [NBITS_W-1:0]    count;
  logic [NBITS_W-1:0]    count_load;

  // 3 * rate: the 600us gap over 5000
  assign dividend = {1'b0, cfg_data, 1'b0} + {2'b00, cfg_data};

  sirc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.calc_start),
    .dividend (dividend),
    .running  (div_running),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  // longer durations from the gap quotient and remainder, exact floors; the header saturates at TICK_MAX
  always_comb begin
    if (rem >= REM_3QUART)      hdr_frac = 2'd3;
    else if (rem >= REM_HALF)   hdr_frac = 2'd2;
    else if (rem >= REM_QUARTER) hdr_frac = 2'd1;
    else                        hdr_frac = 2'd0;
    hdr_sum        = {quo, 2'b00} + {14'd0, hdr_frac};
    hdr_ticks_next = (hdr_sum > {1'b0, TICK_MAX}) ? TICK_MAX : hdr_sum[TICK_W-1:0];
    one_ticks_next = {quo, 1'b0} + {14'd0, (rem >= REM_HALF)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks <= RST_GAP_TICKS;
      one_ticks <= RST_ONE_TICKS;
      hdr_ticks <= RST_HDR_TICKS;
    end else if (div_done) begin
      gap_ticks <= {1'b0, quo};
      one_ticks <= one_ticks_next;
      hdr_ticks <= hdr_ticks_next;
    end
  end

  always_comb begin
    if (32'(frame_bits) > MAX_FRAME_BITS) count_load = NBITS_W'(MAX_FRAME_BITS);
    else                                  count_load = frame_bits;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      frame <= {device_address, command_code};
      count <= count_load;
    end else if (cmd.emit == SYM_BIT) begin
      frame <= {1'b0, frame[FRAME_W-1:1]};
      count <= count - 1'b1;
    end
  end

  assign stat.calc_done = div_done;
  assign stat.no_bits   = (count == '0);
  assign stat.last_bit  = (count == NBITS_W'(1));

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else     strobe <= (cmd.emit != SYM_NONE);
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      SYM_HDR: begin
        first_level  <= 1'b1;
        first_ticks  <= hdr_ticks;
        second_level <= 1'b0;
        second_ticks <= gap_ticks;
        last_symbol  <= 1'b0;
      end
      SYM_BIT: begin
        first_level  <= 1'b1;
        first_ticks  <= frame[0] ? one_ticks : gap_ticks;
        second_level <= 1'b0;
        second_ticks <= gap_ticks;
        last_symbol  <= 1'b0;
      end
      SYM_CLOSE: begin
        first_level  <= 1'b0;
        first_ticks  <= gap_ticks;
        second_level <= 1'b0;
        second_ticks <= '0;
        last_symbol  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_bit_needs_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit == SYM_BIT) |-> (count != '0))
    else $error("bit symbol emitted with no bits left");

  a_no_emit_while_calc: assert property (@(posedge clk) disable iff (rst)
    div_running |-> (cmd.emit == SYM_NONE) && !cmd.load_frame)
    else $error("frame activity while tick table is recalculated");

  a_calc_outside_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.calc_start |-> (cmd.emit == SYM_NONE) && !cmd.load_frame)
    else $error("tick recalculation started during frame activity");

endmodule

`default_nettype wire

// ===== rtl/sirc_ctrl.sv =====
// Controller state machine sequencing table updates and frame symbols.
`default_nettype none

module sirc_ctrl
  import sirc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       cfg_write,
  input  wire sirc_stat_t stat,
  output sirc_cmd_t       cmd,
  output logic            busy
);

  sirc_state_t state;
  sirc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cfg_write)  state_next = ST_CALC;
        else if (start) state_next = ST_HDR;
      end
      ST_CALC: begin
        if (stat.calc_done && !cfg_write) state_next = ST_IDLE;
      end
      ST_HDR: begin
        state_next = stat.no_bits ? ST_CLOSE : ST_BITS;
      end
      ST_BITS: begin
        if (stat.last_bit) state_next = ST_CLOSE;
      end
      ST_CLOSE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // a config write in idle blocks the start transfer of that cycle
  always_comb begin
    cmd.load_frame = 1'b0;
    cmd.calc_start = 1'b0;
    cmd.emit       = SYM_NONE;
    busy           = 1'b1;
    case (state)
      ST_IDLE: begin
        busy           = cfg_write;
        cmd.calc_start = cfg_write;
        cmd.load_frame = start && !cfg_write;
      end
      // a further write restarts the recalculation
      ST_CALC:  cmd.calc_start = cfg_write;
      ST_HDR:   cmd.emit = SYM_HDR;
      ST_BITS:  cmd.emit = SYM_BIT;
      ST_CLOSE: cmd.emit = SYM_CLOSE;
      default:  cmd.emit = SYM_NONE;
    endcase
  end

  a_hdr_then_close: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HDR && stat.no_bits) |=> (state == ST_CLOSE))
    else $error("empty frame did not go straight to closing symbol");

  a_calc_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC && stat.calc_done && !cfg_write) |=> (state == ST_IDLE))
    else $error("tick recalculation did not finish");

  a_accept_goes_hdr: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_HDR))
    else $error("accepted scan code did not start a frame");

endmodule

`default_nettype wire

// ===== rtl/sirc_ir_pulse_encoder_core.sv =====
// Top level of the pulse-width IR frame encoder.
//
// Usage: present command_code, device_address and frame_bits with start high;
// the scan code transfers at a clock edge where start is high and busy is low.
// The block then emits one symbol per cycle on strobe: a header, one symbol per
// data bit (LSB first, frame_bits clamped to MAX_FRAME_BITS) and a closing
// symbol flagged by last_symbol. Each strobe lasts one cycle and the receiver
// cannot stall it. The header strobe is registered from the header state that
// the start transfer enters. An n-bit frame has n + 2 symbols, and busy drops
// while the closing symbol is on the outputs, so a new scan code can transfer
// in that cycle. cfg_write with cfg_data sets the tick rate in hertz; a write
// during a frame is ignored. After a write, the symbol durations are recomputed
// by a pipelined reciprocal multiply by 1/5000: busy is high from the write
// cycle until the new durations are loaded, and a further write in that window
// restarts the recalculation.
// Reset (rst, synchronous) clears the sequencer and loads the 1 MHz durations.
`default_nettype none

module sirc_ir_pulse_encoder_core
  import sirc_pkg::*;
#(
  parameter int MAX_FRAME_BITS = 20
)
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [CMD_W-1:0]   command_code,
  input  wire logic [ADDR_W-1:0]  device_address,
  input  wire logic [NBITS_W-1:0] frame_bits,
  input  wire logic               cfg_write,
  input  wire logic [RATE_W-1:0]  cfg_data,
  output logic                    strobe,
  output logic                    first_level,
  output logic [TICK_W-1:0]       first_ticks,
  output logic                    second_level,
  output logic [TICK_W-1:0]       second_ticks,
  output logic                    last_symbol
);

  sirc_cmd_t  cmd;
  sirc_stat_t stat;

  sirc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_write (cfg_write),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  sirc_dp #(
    .MAX_FRAME_BITS (MAX_FRAME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_data       (cfg_data),
    .command_code   (command_code),
    .device_address (device_address),
    .frame_bits     (frame_bits),
    .strobe         (strobe),
    .first_level    (first_level),
    .first_ticks    (first_ticks),
    .second_level   (second_level),
    .second_ticks   (second_ticks),
    .last_symbol    (last_symbol)
  );

endmodule

`default_nettype wire
